[src/itp_pkg.sv]
// ----------------------------------------------------------------------------
// itp_pkg: shared types and constants for the incircle touch point unit
// Widths of the coordinate, square-root and division datapaths.
// ----------------------------------------------------------------------------
package itp_pkg;

	localparam int COORD_BITS = 16;
	localparam int FRAC_BITS  = 16;
	localparam int OUT_W      = 32;

	// squared distance, even width so it splits into bit pairs
	localparam int D2_W     = 2 * COORD_BITS + 2;
	localparam int SQ_STEPS = D2_W / 2 + FRAC_BITS;
	localparam int ROOT_W   = SQ_STEPS;
	localparam int SQ_REM_W = ROOT_W + 2;
	localparam int DEN_W    = ROOT_W + 1;
	localparam int Q_W      = COORD_BITS + FRAC_BITS;
	localparam int PROD_W   = ROOT_W + COORD_BITS + 1;
	localparam int NUM_W    = PROD_W + 1;
	localparam int SH_W     = NUM_W + FRAC_BITS;

	// stage numbering along the pipe
	localparam int ST_T = SQ_STEPS + 1;
	localparam int ST_M = SQ_STEPS + 2;
	localparam int ST_N = SQ_STEPS + 3;
	localparam int ST_O = SQ_STEPS + Q_W + 4;
	localparam int NSTG = ST_O + 1;

	typedef logic signed [COORD_BITS-1:0] coord_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] ax;
		logic signed [COORD_BITS-1:0] ay;
		logic signed [COORD_BITS-1:0] bx;
		logic signed [COORD_BITS-1:0] by;
		logic signed [COORD_BITS-1:0] cx;
		logic signed [COORD_BITS-1:0] cy;
	} tri_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] touch_ab_x;
		logic signed [OUT_W-1:0] touch_ab_y;
		logic signed [OUT_W-1:0] touch_ca_x;
		logic signed [OUT_W-1:0] touch_ca_y;
		logic                    degenerate;
	} res_t;

	typedef struct packed {
		logic [D2_W-1:0]     rad;
		logic [SQ_REM_W-1:0] rem;
		logic [ROOT_W-1:0]   root;
	} sq_t;

	typedef struct packed {
		logic [DEN_W-1:0] den;
		logic [DEN_W-1:0] rem;
		logic [Q_W-1:0]   dvd;
		logic [Q_W-1:0]   quo;
	} dv_t;

	typedef struct packed {
		logic [3:0] neg;
		logic       dgn;
	} flg_t;

endpackage

[src/itp_if.sv]
// ----------------------------------------------------------------------------
// itp_if: valid/ready channels of the incircle touch point unit
// Vertex channel and touch point channel.
// ----------------------------------------------------------------------------
interface itp_in_if;
	import itp_pkg::*;
	logic valid;
	logic ready;
	tri_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface itp_out_if;
	import itp_pkg::*;
	logic valid;
	logic ready;
	res_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[src/incircle_touch_points_unit.sv]
// ----------------------------------------------------------------------------
// incircle_touch_points_unit: incircle contact points on sides AB and CA
// Fully pipelined; one triangle per cycle while rsp.ready holds.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one triangle (ax..cy, signed integers) per transfer.
//   rsp carries the touch points on AB and CA as signed Q16.16 plus a
//   degenerate flag; when a weight sum is zero all coordinates are zero.
// Timing:
//   NSTG = 70 register stages: one squared-distance stage, 33 square-root
//   cells (one root bit each), the tangent, product and numerator stages,
//   32 divider cells (one quotient bit each) and the output register.
//   The first stage loads at the transfer edge. Throughput is one triangle
//   per cycle while rsp.ready holds.
// Stall:
//   Every stage has its own valid bit. A stage loads when it is empty or
//   its successor loads, so bubbles collapse: while the output register
//   holds an untaken result, req.ready stays high until the pipe is full.
// Reset:
//   arst_n clears all valid bits; no result is pending afterwards.
// ----------------------------------------------------------------------------
module incircle_touch_points_unit (
	input  logic       clk,
	input  logic       arst_n,
	itp_in_if.sink     req,
	itp_out_if.source  rsp
);
	import itp_pkg::*;

	function automatic logic [D2_W-1:0] dist2(coord_t px, coord_t py, coord_t qx, coord_t qy);
		logic signed [COORD_BITS:0]     dx;
		logic signed [COORD_BITS:0]     dy;
		logic signed [2*COORD_BITS+1:0] sx;
		logic signed [2*COORD_BITS+1:0] sy;
		dx = (COORD_BITS+1)'(px) - (COORD_BITS+1)'(qx);
		dy = (COORD_BITS+1)'(py) - (COORD_BITS+1)'(qy);
		sx = (2*COORD_BITS+2)'(dx) * (2*COORD_BITS+2)'(dx);
		sy = (2*COORD_BITS+2)'(dy) * (2*COORD_BITS+2)'(dy);
		return D2_W'(sx) + D2_W'(sy);
	endfunction

	// (p + q - m) / 2 toward zero; negative sums clamp to zero
	function automatic logic [ROOT_W-1:0] half_sum(logic [ROOT_W-1:0] p, logic [ROOT_W-1:0] q,
			logic [ROOT_W-1:0] m);
		logic signed [ROOT_W+1:0] s;
		s = $signed({2'b00, p}) + $signed({2'b00, q}) - $signed({2'b00, m});
		return s[ROOT_W+1] ? '0 : s[ROOT_W:1];
	endfunction

	function automatic logic signed [PROD_W-1:0] mulw(logic [ROOT_W-1:0] w, coord_t c);
		return PROD_W'($signed({1'b0, w})) * PROD_W'(c);
	endfunction

	// ---------------- stage control ----------------
	logic [NSTG-1:0] vld_q;
	logic [NSTG-1:0] en;

	assign en[NSTG-1] = !vld_q[NSTG-1] || rsp.ready;
	for (genvar i = 0; i < NSTG - 1; i++) begin : g_en
		assign en[i] = !vld_q[i] || en[i+1];
	end

	assign req.ready = en[0];
	assign rsp.valid = vld_q[NSTG-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= (vld_q & ~en) | ({vld_q[NSTG-2:0], req.valid} & en);
		end
	end

	// coordinates ride along until the product stage
	tri_t crd_q [0:ST_T];

	always_ff @(posedge clk) begin
		if (en[0]) begin
			crd_q[0] <= req.data;
		end
		for (int i = 1; i <= ST_T; i++) begin
			if (en[i]) begin
				crd_q[i] <= crd_q[i-1];
			end
		end
	end

	// ---------------- s1: squared side lengths ----------------
	// lane 0: AB, lane 1: BC, lane 2: CA
	sq_t sq_s1 [3];

	always_ff @(posedge clk) begin
		if (en[0]) begin
			sq_s1[0] <= '{rad: dist2(req.data.ax, req.data.ay, req.data.bx, req.data.by),
				rem: '0, root: '0};
			sq_s1[1] <= '{rad: dist2(req.data.bx, req.data.by, req.data.cx, req.data.cy),
				rem: '0, root: '0};
			sq_s1[2] <= '{rad: dist2(req.data.cx, req.data.cy, req.data.ax, req.data.ay),
				rem: '0, root: '0};
		end
	end

	// ---------------- square root chains ----------------
	sq_t sq_c [3][1:SQ_STEPS];

	for (genvar l = 0; l < 3; l++) begin : g_sq_lane
		for (genvar k = 1; k <= SQ_STEPS; k++) begin : g_sq_cell
			if (k == 1) begin : g_first
				itp_sqrt_cell u_cell (.clk(clk), .en(en[k]), .prev(sq_s1[l]), .next(sq_c[l][k]));
			end else begin : g_rest
				itp_sqrt_cell u_cell (.clk(clk), .en(en[k]), .prev(sq_c[l][k-1]),
					.next(sq_c[l][k]));
			end
		end
	end

	// ---------------- s2: tangent lengths ----------------
	logic [ROOT_W-1:0] lab;
	logic [ROOT_W-1:0] lbc;
	logic [ROOT_W-1:0] lca;
	logic [ROOT_W-1:0] ta_s2;
	logic [ROOT_W-1:0] tb_s2;
	logic [ROOT_W-1:0] tc_s2;

	assign lab = sq_c[0][SQ_STEPS].root;
	assign lbc = sq_c[1][SQ_STEPS].root;
	assign lca = sq_c[2][SQ_STEPS].root;

	always_ff @(posedge clk) begin
		if (en[ST_T]) begin
			ta_s2 <= half_sum(lab, lca, lbc);
			tb_s2 <= half_sum(lab, lbc, lca);
			tc_s2 <= half_sum(lbc, lca, lab);
		end
	end

	// ---------------- s3: weight products ----------------
	// pairs per lane: AB x, AB y, CA x, CA y
	logic signed [PROD_W-1:0] p_s3 [8];
	logic [DEN_W-1:0]         den_ab_s3;
	logic [DEN_W-1:0]         den_ca_s3;

	always_ff @(posedge clk) begin
		if (en[ST_M]) begin
			p_s3[0]   <= mulw(tb_s2, crd_q[ST_T].ax);
			p_s3[1]   <= mulw(ta_s2, crd_q[ST_T].bx);
			p_s3[2]   <= mulw(tb_s2, crd_q[ST_T].ay);
			p_s3[3]   <= mulw(ta_s2, crd_q[ST_T].by);
			p_s3[4]   <= mulw(ta_s2, crd_q[ST_T].cx);
			p_s3[5]   <= mulw(tc_s2, crd_q[ST_T].ax);
			p_s3[6]   <= mulw(ta_s2, crd_q[ST_T].cy);
			p_s3[7]   <= mulw(tc_s2, crd_q[ST_T].ay);
			den_ab_s3 <= {1'b0, ta_s2} + {1'b0, tb_s2};
			den_ca_s3 <= {1'b0, ta_s2} + {1'b0, tc_s2};
		end
	end

	// ---------------- s4: numerator magnitude, divider setup ----------------
	logic signed [NUM_W-1:0] num [4];
	logic [NUM_W-1:0]        mag [4];
	logic [SH_W-1:0]         sh [4];
	logic [3:0]              neg;
	dv_t                     dv_s4 [4];
	flg_t                    flg_q [0:Q_W];

	always_comb begin
		for (int l = 0; l < 4; l++) begin
			num[l] = NUM_W'(p_s3[2*l]) + NUM_W'(p_s3[2*l+1]);
			neg[l] = num[l][NUM_W-1];
			mag[l] = neg[l] ? NUM_W'(-num[l]) : NUM_W'(num[l]);
			sh[l]  = {mag[l], {FRAC_BITS{1'b0}}};
		end
	end

	// the quotient fits Q_W bits, so the bits above them start below den
	always_ff @(posedge clk) begin
		if (en[ST_N]) begin
			for (int l = 0; l < 4; l++) begin
				dv_s4[l] <= '{den: (l < 2) ? den_ab_s3 : den_ca_s3,
					rem: DEN_W'(sh[l] >> Q_W), dvd: sh[l][Q_W-1:0], quo: '0};
			end
			flg_q[0] <= '{neg: neg, dgn: (den_ab_s3 == '0) || (den_ca_s3 == '0)};
		end
		for (int k = 1; k <= Q_W; k++) begin
			if (en[ST_N+k]) begin
				flg_q[k] <= flg_q[k-1];
			end
		end
	end

	// ---------------- divider chains ----------------
	dv_t dv_c [4][1:Q_W];

	for (genvar l = 0; l < 4; l++) begin : g_dv_lane
		for (genvar k = 1; k <= Q_W; k++) begin : g_dv_cell
			if (k == 1) begin : g_first
				itp_div_cell u_cell (.clk(clk), .en(en[ST_N+k]), .prev(dv_s4[l]),
					.next(dv_c[l][k]));
			end else begin : g_rest
				itp_div_cell u_cell (.clk(clk), .en(en[ST_N+k]), .prev(dv_c[l][k-1]),
					.next(dv_c[l][k]));
			end
		end
	end

	// ---------------- s5: sign, degenerate mask, output register ----------------
	logic signed [Q_W:0]     sv [4];
	logic signed [OUT_W-1:0] ov [4];
	res_t                    out_s5;

	always_comb begin
		for (int l = 0; l < 4; l++) begin
			sv[l] = flg_q[Q_W].neg[l] ? -$signed({1'b0, dv_c[l][Q_W].quo})
				: $signed({1'b0, dv_c[l][Q_W].quo});
			ov[l] = flg_q[Q_W].dgn ? '0 : OUT_W'(sv[l]);
		end
	end

	always_ff @(posedge clk) begin
		if (en[ST_O]) begin
			out_s5 <= '{touch_ab_x: ov[0], touch_ab_y: ov[1], touch_ca_x: ov[2],
				touch_ca_y: ov[3], degenerate: flg_q[Q_W].dgn};
		end
	end

	assign rsp.data = out_s5;

endmodule

[src/itp_sqrt_cell.sv]
// ----------------------------------------------------------------------------
// itp_sqrt_cell: one digit step of the square root chain
// Takes one bit pair of the radicand and settles one root bit.
// ----------------------------------------------------------------------------
module itp_sqrt_cell (
	input  logic         clk,
	input  logic         en,
	input  itp_pkg::sq_t prev,
	output itp_pkg::sq_t next
);
	import itp_pkg::*;

	logic [1:0]          pair;
	logic [SQ_REM_W+1:0] rem_sh;
	logic [SQ_REM_W+1:0] trial;
	logic                ge;
	sq_t                 nxt;

	always_comb begin
		pair     = prev.rad[D2_W-1 -: 2];
		rem_sh   = {prev.rem, pair};
		trial    = (SQ_REM_W+2)'({prev.root, 2'b01});
		ge       = rem_sh >= trial;
		nxt.rad  = prev.rad << 2;
		nxt.rem  = ge ? SQ_REM_W'(rem_sh - trial) : SQ_REM_W'(rem_sh);
		nxt.root = {prev.root[ROOT_W-2:0], ge};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			next <= nxt;
		end
	end

endmodule

[src/itp_div_cell.sv]
// ----------------------------------------------------------------------------
// itp_div_cell: one restoring step of the divider chain
// Brings down one dividend bit and settles one quotient bit.
// ----------------------------------------------------------------------------
module itp_div_cell (
	input  logic         clk,
	input  logic         en,
	input  itp_pkg::dv_t prev,
	output itp_pkg::dv_t next
);
	import itp_pkg::*;

	logic [DEN_W:0] rem_sh;
	logic [DEN_W:0] dsub;
	logic           ge;
	dv_t            nxt;

	always_comb begin
		rem_sh  = {prev.rem, prev.dvd[Q_W-1]};
		dsub    = {1'b0, prev.den};
		ge      = rem_sh >= dsub;
		nxt.den = prev.den;
		nxt.rem = ge ? DEN_W'(rem_sh - dsub) : DEN_W'(rem_sh);
		nxt.dvd = prev.dvd << 1;
		nxt.quo = {prev.quo[Q_W-2:0], ge};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			next <= nxt;
		end
	end

endmodule

[sim/tb.sv]
// ----------------------------------------------------------------------------
// tb: testbench of the incircle touch point unit
// Drives triangles over the request channel under random idling and stalls,
// predicts each touch point result in integer arithmetic and compares it
// field by field with every response transfer, in order.
// ----------------------------------------------------------------------------
module tb;
	import itp_pkg::*;

	localparam int PIPE_LAT = 70;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	itp_in_if  req ();
	itp_out_if rsp ();

	incircle_touch_points_unit uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req.sink),
		.rsp    (rsp.source)
	);

	always #5 clk = ~clk;

	// idling percentages, changed between phases
	int src_idle = 0;
	int snk_stall = 0;
	int n_err = 0;

	res_t touch_q[$];

	initial begin
		req.valid = 1'b0;
		req.data  = '0;
		rsp.ready = 1'b0;
	end

	// floor(sqrt(d2) * 2^FRAC_BITS), bit by bit over 48 root bits
	function automatic longint unsigned side_root(longint unsigned d2);
		longint unsigned root;
		longint unsigned x;
		logic [127:0] sq;
		root = 0;
		for (int b = 47; b >= 0; b--) begin
			x = root | (64'd1 << b);
			sq = 128'(x) * 128'(x);
			if (sq <= (128'(d2) << (2 * FRAC_BITS)))
				root = x;
		end
		return root;
	endfunction

	function automatic longint unsigned seg_len(longint px, longint py, longint qx,
		longint qy);
		longint dx;
		longint dy;
		dx = px - qx;
		dy = py - qy;
		return side_root(longint'(dx * dx + dy * dy));
	endfunction

	function automatic longint unsigned tangent(longint unsigned p, longint unsigned q,
		longint unsigned m);
		longint s;
		s = (longint'(p) + longint'(q) - longint'(m)) / 2;
		return s < 0 ? 0 : longint'(s);
	endfunction

	// trunc((wp*p + wq*q) * 2^FRAC / (wp + wq)), low 32 bits
	function automatic logic signed [OUT_W-1:0] blend(longint unsigned wp, longint p,
		longint unsigned wq, longint q);
		logic signed [127:0] num;
		logic signed [127:0] den;
		logic signed [127:0] quo;
		num = ($signed({64'd0, wp}) * 128'(p) + $signed({64'd0, wq}) * 128'(q))
			<<< FRAC_BITS;
		den = $signed({64'd0, wp + wq});
		quo = num / den;
		return quo[OUT_W-1:0];
	endfunction

	function automatic res_t touch_points(tri_t t);
		res_t r;
		longint unsigned lab, lbc, lca, ta, tb_, tc;
		lab = seg_len(t.ax, t.ay, t.bx, t.by);
		lbc = seg_len(t.bx, t.by, t.cx, t.cy);
		lca = seg_len(t.cx, t.cy, t.ax, t.ay);
		ta  = tangent(lab, lca, lbc);
		tb_ = tangent(lab, lbc, lca);
		tc  = tangent(lbc, lca, lab);
		r = '0;
		if (ta + tb_ == 0 || ta + tc == 0) begin
			r.degenerate = 1'b1;
		end else begin
			r.touch_ab_x = blend(tb_, t.ax, ta, t.bx);
			r.touch_ab_y = blend(tb_, t.ay, ta, t.by);
			r.touch_ca_x = blend(ta, t.cx, tc, t.ax);
			r.touch_ca_y = blend(ta, t.cy, tc, t.ay);
		end
		return r;
	endfunction

	// one triangle transfer; valid stays high across back-to-back items
	task automatic send_tri(tri_t t);
		while ($urandom_range(99) < src_idle) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid <= 1'b1;
		req.data  <= t;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
		touch_q.push_back(touch_points(t));
	endtask

	task automatic go_idle();
		req.valid <= 1'b0;
	endtask

	// response side: random stall, then check each transfer
	always @(posedge clk) begin
		res_t exp_r;
		if (arst_n) begin
			if (rsp.valid && rsp.ready) begin
				if (touch_q.size() == 0) begin
					$error("unexpected touch point transfer");
					n_err++;
				end else begin
					exp_r = touch_q.pop_front();
					if (rsp.data.touch_ab_x !== exp_r.touch_ab_x) begin
						$error("touch_ab_x exp %0d got %0d", exp_r.touch_ab_x,
							rsp.data.touch_ab_x);
						n_err++;
					end
					if (rsp.data.touch_ab_y !== exp_r.touch_ab_y) begin
						$error("touch_ab_y exp %0d got %0d", exp_r.touch_ab_y,
							rsp.data.touch_ab_y);
						n_err++;
					end
					if (rsp.data.touch_ca_x !== exp_r.touch_ca_x) begin
						$error("touch_ca_x exp %0d got %0d", exp_r.touch_ca_x,
							rsp.data.touch_ca_x);
						n_err++;
					end
					if (rsp.data.touch_ca_y !== exp_r.touch_ca_y) begin
						$error("touch_ca_y exp %0d got %0d", exp_r.touch_ca_y,
							rsp.data.touch_ca_y);
						n_err++;
					end
					if (rsp.data.degenerate !== exp_r.degenerate) begin
						$error("degenerate exp %0b got %0b", exp_r.degenerate,
							rsp.data.degenerate);
						n_err++;
					end
				end
			end
			rsp.ready <= ($urandom_range(99) >= snk_stall);
		end
	end

	function automatic tri_t mk_tri(int ax, int ay, int bx, int by, int cx, int cy);
		tri_t t;
		t.ax = coord_t'(ax); t.ay = coord_t'(ay); t.bx = coord_t'(bx);
		t.by = coord_t'(by); t.cx = coord_t'(cx); t.cy = coord_t'(cy);
		return t;
	endfunction

	function automatic coord_t rnd_coord();
		case ($urandom_range(3))
			0: return coord_t'($urandom);
			1: return coord_t'(int'($urandom_range(32)) - 16);
			2: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
			default: return coord_t'(int'($urandom_range(2000)) - 1000);
		endcase
	endfunction

	// extremes, collinear and coincident vertices
	task automatic test_directed();
		send_tri(mk_tri(0, 0, 0, 0, 0, 0));
		send_tri(mk_tri(0, 0, 3, 0, 0, 4));
		send_tri(mk_tri(0, 0, 1, 0, 2, 0));
		send_tri(mk_tri(5, 5, 5, 5, 9, 1));
		send_tri(mk_tri(1, 1, 4, 5, 1, 1));
		send_tri(mk_tri(-32768, -32768, 32767, 32767, -32768, 32767));
		send_tri(mk_tri(32767, -32768, -32768, 32767, 32767, 32767));
		send_tri(mk_tri(-32768, -32768, 32767, -32768, 32767, 32767));
		send_tri(mk_tri(-32768, 0, 32767, 0, 0, 1));
		send_tri(mk_tri(0, 0, 1, 1, 2, 2));
		send_tri(mk_tri(-1, -1, 1, 0, 0, 1));
		send_tri(mk_tri(0, 0, 0, 1, 1, 0));
		send_tri(mk_tri(-32768, -32768, -32768, -32768, 32767, 32767));
		send_tri(mk_tri(32767, 32767, 32767, 32767, 32767, 32767));
		send_tri(mk_tri(0, 0, 65, 0, 130, 1));
		send_tri(mk_tri(100, -7, -3, 40, 22, 22));
		go_idle();
	endtask

	task automatic test_random(int n);
		tri_t t;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(9) == 0) begin
				// repeated vertex or right triangle with axis-parallel legs
				t.ax = rnd_coord(); t.ay = rnd_coord();
				t.bx = $urandom_range(1) ? t.ax : rnd_coord();
				t.by = t.ay;
				t.cx = t.bx; t.cy = $urandom_range(1) ? t.by : rnd_coord();
			end else begin
				t = mk_tri(rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(),
					rnd_coord(), rnd_coord());
			end
			send_tri(t);
		end
		go_idle();
	endtask

	task automatic drain();
		while (touch_q.size() != 0)
			@(posedge clk);
		repeat (PIPE_LAT + 10) @(posedge clk);
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		src_idle = 19; snk_stall = 65;
		test_directed();
		test_random(340);
		src_idle = 65; snk_stall = 19;
		test_random(340);
		src_idle = 0; snk_stall = 0;
		test_random(350);
		drain();
		if (n_err == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		#2000000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule

[sim.f]
src/itp_pkg.sv
src/itp_if.sv
src/itp_sqrt_cell.sv
src/itp_div_cell.sv
src/incircle_touch_points_unit.sv
sim/tb.sv
